// ===== rtl/cfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants of the CSV field splitter.
// ----------------------------------------------------------------------------
package cfs_pkg;

    localparam int OFFSET_BITS_DEFAULT = 32;
    localparam int BYTE_W              = 8;
    localparam int SPAN_W              = 32;

    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_LEAD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PLAIN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QUOTED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QPEND  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AFTER  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HALT   = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } t_item;

    typedef struct packed {
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
        logic              record_end;
        logic              text_done;
        logic              malformed;
    } t_result;

    function automatic logic is_white(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || (b == CH_CR) || (b == CH_TAB);
    endfunction

    function automatic logic is_delim(input logic [BYTE_W-1:0] b);
        return (b == CH_COMMA) || (b == CH_NL);
    endfunction

endpackage

// ===== rtl/cfs_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_in_stage
// Input register: holds one accepted text request until the scanner takes it.
// ----------------------------------------------------------------------------
module cfs_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cfs_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output cfs_pkg::t_item o_item
);

    logic           r_valid;
    logic           n_valid;
    cfs_pkg::t_item r_item;
    logic           w_fire;

    assign o_ready = !r_valid || i_advance;
    assign w_fire  = i_valid && o_ready;
    assign n_valid = w_fire ? 1'b1 : (i_advance ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/cfs_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_scanner
// Field scan state: offset, mode and span marks, updated once per request.
// ----------------------------------------------------------------------------
module cfs_scanner #(
    parameter int OFFSET_BITS = cfs_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  cfs_pkg::t_item   i_item,
    output logic             o_res_valid,
    output cfs_pkg::t_result o_result
);

    logic [OFFSET_BITS-1:0]     r_offset, n_offset;
    logic [OFFSET_BITS-1:0]     r_begin, n_begin;
    logic [OFFSET_BITS-1:0]     r_finish, n_finish;
    logic [cfs_pkg::MODE_W-1:0] r_mode, n_mode;

    logic [OFFSET_BITS-1:0]     w_next;
    logic [OFFSET_BITS-1:0]     w_prev;
    logic [OFFSET_BITS-1:0]     w_fin;
    logic [OFFSET_BITS-1:0]     w_s, w_e;
    logic [cfs_pkg::BYTE_W-1:0] w_b;
    logic                       w_quote, w_delim, w_white, w_nl;
    logic                       w_after;
    logic                       w_valid, w_rec, w_done, w_bad;

    assign w_b     = i_item.text_byte;
    assign w_next  = r_offset + OFFSET_BITS'(1);
    assign w_prev  = r_offset - OFFSET_BITS'(1);
    assign w_quote = (w_b == cfs_pkg::CH_QUOTE);
    assign w_nl    = (w_b == cfs_pkg::CH_NL);
    assign w_delim = cfs_pkg::is_delim(w_b);
    assign w_white = cfs_pkg::is_white(w_b);
    assign w_after = ((r_mode == cfs_pkg::MODE_QPEND) && !w_quote)
                     || (r_mode == cfs_pkg::MODE_AFTER);
    assign w_fin   = (r_mode == cfs_pkg::MODE_QPEND) ? w_prev : r_finish;

    always_comb begin
        n_offset = r_offset;
        n_begin  = r_begin;
        n_finish = r_finish;
        n_mode   = r_mode;
        w_valid  = 1'b0;
        w_s      = r_begin;
        w_e      = r_offset;
        w_rec    = 1'b0;
        w_done   = 1'b0;
        w_bad    = 1'b0;
        if (i_item.end_of_text) begin
            w_rec  = 1'b1;
            w_done = 1'b1;
            unique case (r_mode)
                cfs_pkg::MODE_LEAD, cfs_pkg::MODE_PLAIN, cfs_pkg::MODE_QUOTED: begin
                    w_valid = 1'b1;
                end
                cfs_pkg::MODE_QPEND: begin
                    w_valid = 1'b1;
                    w_e     = w_prev;
                end
                cfs_pkg::MODE_AFTER: begin
                    w_valid = 1'b1;
                    w_e     = r_finish;
                end
                default: begin
                    w_valid = 1'b0;
                end
            endcase
            n_offset = '0;
            n_begin  = '0;
            n_finish = '0;
            n_mode   = cfs_pkg::MODE_LEAD;
        end else if (w_after) begin
            n_offset = w_next;
            n_finish = w_fin;
            n_mode   = cfs_pkg::MODE_AFTER;
            w_e      = w_fin;
            if (w_delim) begin
                w_valid = 1'b1;
                w_rec   = w_nl;
                n_begin = w_next;
                n_mode  = cfs_pkg::MODE_LEAD;
            end else if (!w_white) begin
                w_valid = 1'b1;
                w_rec   = 1'b1;
                w_done  = 1'b1;
                w_bad   = 1'b1;
                n_mode  = cfs_pkg::MODE_HALT;
            end
        end else begin
            unique case (r_mode)
                cfs_pkg::MODE_LEAD, cfs_pkg::MODE_PLAIN: begin
                    n_offset = w_next;
                    if (w_delim) begin
                        w_valid = 1'b1;
                        w_rec   = w_nl;
                        n_begin = w_next;
                        n_mode  = cfs_pkg::MODE_LEAD;
                    end else if (r_mode == cfs_pkg::MODE_LEAD) begin
                        if (w_quote) begin
                            n_begin = w_next;
                            n_mode  = cfs_pkg::MODE_QUOTED;
                        end else if (!w_white) begin
                            n_mode = cfs_pkg::MODE_PLAIN;
                        end
                    end
                end
                cfs_pkg::MODE_QUOTED: begin
                    n_offset = w_next;
                    if (w_quote) begin
                        n_mode = cfs_pkg::MODE_QPEND;
                    end
                end
                cfs_pkg::MODE_QPEND: begin
                    n_offset = w_next;
                    n_mode   = cfs_pkg::MODE_QUOTED;
                end
                default: begin
                    n_offset = r_offset;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_begin  <= '0;
            r_finish <= '0;
            r_mode   <= cfs_pkg::MODE_LEAD;
        end else if (i_fire) begin
            r_offset <= n_offset;
            r_begin  <= n_begin;
            r_finish <= n_finish;
            r_mode   <= n_mode;
        end
    end

    assign o_res_valid         = i_fire && w_valid;
    assign o_result.span_start = cfs_pkg::SPAN_W'(w_s);
    assign o_result.span_end   = cfs_pkg::SPAN_W'(w_e);
    assign o_result.record_end = w_rec;
    assign o_result.text_done  = w_done;
    assign o_result.malformed  = w_bad;

    a_eot_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.end_of_text |=> (r_offset == '0) && (r_mode == cfs_pkg::MODE_LEAD))
        else $error("end of text did not return scan state to reset");

    a_bad_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_result.malformed |=> (r_mode == cfs_pkg::MODE_HALT))
        else $error("malformed field did not halt the scan");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == cfs_pkg::MODE_HALT) |-> !o_res_valid)
        else $error("result produced while halted");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_result.text_done |-> o_result.record_end)
        else $error("final field not marked as end of record");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= cfs_pkg::MODE_HALT)
        else $error("scan mode outside its code range");

endmodule

// ===== rtl/cfs_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_out_stage
// Result register: holds one field request until the sink takes it.
// ----------------------------------------------------------------------------
module cfs_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cfs_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_advance,
    output logic             o_valid,
    output cfs_pkg::t_result o_result
);

    logic             r_valid;
    logic             n_valid;
    cfs_pkg::t_result r_result;

    assign o_advance = !r_valid || i_ready;
    assign n_valid   = i_load ? 1'b1 : (i_ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/csv_field_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits comma separated text into field spans, one text byte per request.
//
//   channel   dir  width  contents
//   s_axis    in   8+1    tdata: text_byte; tlast: end_of_text
//   m_axis    out  64+1+2 tdata: span_start, span_end; tlast: record_end;
//                         tuser: text_done, malformed
//
// One byte per cycle while m_axis does not stall; a field leaves after its
// delimiter is taken (input register, then scan update into result register).
// All scan state updates in the single scan stage between the two registers.
// Reset is synchronous, active low, and returns the scanner to field start.
// A stalled m_axis holds the result and the scanner; s_axis tready drops in
// the same cycle once the input register is full and cannot advance.
// ----------------------------------------------------------------------------
module csv_field_splitter #(
    parameter int OFFSET_BITS = cfs_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    input  logic        i_s_axis_tlast,   // end_of_text
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] span_start, [63:32] span_end
    output logic        o_m_axis_tlast,   // record_end
    output logic [1:0]  o_m_axis_tuser    // [0] text_done, [1] malformed
);

    cfs_pkg::t_item   w_in_item;
    cfs_pkg::t_item   w_item;
    cfs_pkg::t_result w_scan_res;
    cfs_pkg::t_result w_out_res;
    logic             w_item_valid;
    logic             w_advance;
    logic             w_res_valid;

    assign w_in_item.text_byte   = i_s_axis_tdata;
    assign w_in_item.end_of_text = i_s_axis_tlast;

    cfs_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    cfs_scanner #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_item_valid && w_advance),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_result    (w_scan_res)
    );

    cfs_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_res_valid),
        .i_result  (w_scan_res),
        .i_ready   (i_m_axis_tready),
        .o_advance (w_advance),
        .o_valid   (o_m_axis_tvalid),
        .o_result  (w_out_res)
    );

    assign o_m_axis_tdata = {w_out_res.span_end, w_out_res.span_start};
    assign o_m_axis_tlast = w_out_res.record_end;
    assign o_m_axis_tuser = {w_out_res.malformed, w_out_res.text_done};

endmodule
